// ===== design/itoa_pkg.sv =====
// Shared constants, types and helpers for the integer to ASCII radix converter.
// Used by every module of the block; depends on nothing.
package itoa_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int DIGIT_W     = 6;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);
  localparam int ITER_W      = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [5:0] RADIX_RAW  = 6'd0;
  localparam logic [5:0] RADIX_UNARY = 6'd1;
  localparam logic [5:0] RADIX_BIN  = 6'd2;
  localparam logic [5:0] RADIX_DEC  = 6'd10;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {{(8 - DIGIT_W){1'b0}}, d};
    if (d8 < 8'd10) begin
      return CHAR_ZERO + d8;
    end
    return CHAR_A + (d8 - 8'd10);
  endfunction

endpackage

// ===== design/integer_to_ascii_radix.sv =====
// Integer to ASCII radix converter, top level with the conversion sequencer.
// Each digit comes from a division in the shared divider, and each character is then
// emitted through the read, data and push states.
// One request is worked at a time; the bit-serial divider's VALUE_WIDTH iterations set the rate.
// Reset (rst_n, synchronous, active low) returns the sequencer and output to idle/empty.
module integer_to_ascii_radix
  import itoa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], base[37:32], zero fill [39:38]
  input  logic        in_tuser,   // is_signed
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_out[7:0]
  output logic        out_tlast   // last
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_DIV,
    ST_RD,
    ST_DATA,
    ST_PUSH
  } state_t;

  state_t                 state_r, state_nxt;
  state_t                 after_r, after_nxt;
  logic [VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIGIT_W-1:0]     base_r, base_nxt;
  logic [7:0]             push_char_r, push_char_nxt;
  logic                   push_last_r, push_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_req;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [DIGIT_W-1:0]     in_base;
  logic [DIGIT_W-1:0]     eff_base;
  logic                   in_neg;

  div_stat_t              div_stat;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;

  logic                   st_we;
  logic [IDX_W-1:0]       st_raddr;
  logic [DIGIT_W-1:0]     st_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign in_value = in_tdata[VALUE_WIDTH-1:0];
  assign in_base  = in_tdata[37:32];
  // A unary radix would never terminate, so it converts as binary.
  assign eff_base = (in_base == RADIX_UNARY) ? RADIX_BIN : in_base;
  // Only decimal shows a sign; other radixes print the raw bit pattern.
  assign in_neg   = (eff_base == RADIX_DEC) && in_tuser && in_value[VALUE_WIDTH-1];

  // Digits are read back most significant first, from the top of the store down.
  assign st_raddr  = IDX_W'(cnt_r - CNT_W'(1));
  assign st_we     = (state_r == ST_DIV) && div_stat.done;
  assign div_start = (state_r == ST_CHK) && (quot_r != '0) && (cnt_r < CNT_W'(VALUE_WIDTH));

  itoa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (quot_r),
    .divisor  (base_r),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  itoa_store u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (div_rem),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    base_nxt      = base_r;
    push_char_nxt = push_char_r;
    push_last_nxt = push_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          base_nxt = eff_base;
          cnt_nxt  = '0;
          quot_nxt = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
          if (in_base == RADIX_RAW) begin
            // Raw byte mode passes the low byte through as a single character.
            push_char_nxt = in_tdata[7:0];
            push_last_nxt = 1'b1;
            after_nxt     = ST_IDLE;
            state_nxt     = ST_PUSH;
          end else if (in_neg) begin
            push_char_nxt = CHAR_MINUS;
            push_last_nxt = 1'b0;
            after_nxt     = ST_CHK;
            state_nxt     = ST_PUSH;
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end
      ST_CHK: begin
        if (div_start) begin
          state_nxt = ST_DIV;
        end else if (cnt_r == '0) begin
          // A zero value still prints one digit.
          push_char_nxt = CHAR_ZERO;
          push_last_nxt = 1'b1;
          after_nxt     = ST_IDLE;
          state_nxt     = ST_PUSH;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          quot_nxt  = div_quot;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_CHK;
        end
      end
      ST_RD: begin
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        push_char_nxt = digit_char(st_rdata);
        push_last_nxt = (cnt_r == '0);
        after_nxt     = (cnt_r == '0) ? ST_IDLE : ST_RD;
        state_nxt     = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = push_char_r;
          out_last_nxt  = push_last_r;
          state_nxt     = after_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      after_r     <= ST_IDLE;
      cnt_r       <= '0;
      quot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      quot_r      <= quot_nxt;
      base_r      <= base_nxt;
      push_char_r <= push_char_nxt;
      push_last_r <= push_last_nxt;
      out_valid_r <= out_valid_nxt;
      out_char_r  <= out_char_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // A finished division is only ever seen while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // The digit count never runs past the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(VALUE_WIDTH))
    else $error("digit count exceeds store depth");

  // Once a request is taken, no further request is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_req |=> !in_tready)
    else $error("input accepted while a conversion is in progress");

endmodule

// ===== design/itoa_div.sv =====
// Iterative restoring divider: VALUE_WIDTH-bit dividend by a 6-bit radix,
// one quotient bit per cycle. Depends on itoa_pkg.
module itoa_div
  import itoa_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [DIGIT_W-1:0]     divisor,
  output div_stat_t              stat,
  output logic [VALUE_WIDTH-1:0] quot,
  output logic [DIGIT_W-1:0]     rem
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [ITER_W-1:0]      iter_r, iter_nxt;
  logic [VALUE_WIDTH-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [DIGIT_W-1:0]     div_r, div_nxt;
  logic [DIGIT_W:0]       trial;
  logic                   ge;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem_r, q_r[VALUE_WIDTH-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? DIGIT_W'(trial - {1'b0, div_r}) : DIGIT_W'(trial);
      q_nxt    = {q_r[VALUE_WIDTH-2:0], ge};
      iter_nxt = iter_r + ITER_W'(1);
      if (iter_r == ITER_W'(VALUE_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      div_r  <= div_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;
  assign rem       = rem_r;

endmodule

// ===== design/itoa_store.sv =====
// Digit store: one write port and one registered read port for digit values.
// Depends on itoa_pkg.
module itoa_store
  import itoa_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [DIGIT_W-1:0] wdata,
  input  logic [IDX_W-1:0]   raddr,
  output logic [DIGIT_W-1:0] rdata
);

  logic [DIGIT_W-1:0] mem [VALUE_WIDTH];
  logic [DIGIT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
